/* sv/r2q_pkg.sv */
// shared types and constants for the rotation matrix to quaternion pipeline
// used by every module of the block; no dependencies
package r2q_pkg;

  // number format and datapath sizes
  localparam int unsigned FracBits      = 14;
  localparam int unsigned DataW         = 16;
  localparam int unsigned DiffW         = DataW + 1;
  localparam int unsigned RemW          = 32;
  localparam int unsigned DivRemW       = 33;
  localparam int unsigned QuoW          = 15;
  localparam logic [DataW-1:0] One      = DataW'(1) << FracBits;

  // iteration counts and stage split
  localparam int unsigned SqrtIters     = 16;
  localparam int unsigned DivIters      = QuoW + 1;
  localparam int unsigned StepsPerStage = 4;
  localparam int unsigned SqrtStages    = SqrtIters / StepsPerStage;
  localparam int unsigned DivStages     = DivIters / StepsPerStage;
  localparam int unsigned NumStages     = 2 + SqrtStages + DivStages;
  localparam int unsigned Lanes         = 3;

  // which quaternion component comes straight from the root
  typedef enum logic [1:0] {
    LEAD_W = 2'd0,
    LEAD_X = 2'd1,
    LEAD_Y = 2'd2,
    LEAD_Z = 2'd3
  } lead_e;

  typedef struct packed {
    logic signed [DataW-1:0] m00;
    logic signed [DataW-1:0] m01;
    logic signed [DataW-1:0] m02;
    logic signed [DataW-1:0] m10;
    logic signed [DataW-1:0] m11;
    logic signed [DataW-1:0] m12;
    logic signed [DataW-1:0] m20;
    logic signed [DataW-1:0] m21;
    logic signed [DataW-1:0] m22;
  } req_t;

  typedef struct packed {
    logic signed [DataW-1:0] qw;
    logic signed [DataW-1:0] qx;
    logic signed [DataW-1:0] qy;
    logic signed [DataW-1:0] qz;
    logic                    degenerate;
  } rsp_t;

  // state carried down the pipeline; lanes hold the three non-lead
  // components in ascending order w, x, y, z
  typedef struct packed {
    logic                             deg;
    lead_e                            lead;
    logic [Lanes-1:0][DiffW-1:0]      diff;
    logic [RemW-1:0]                  sq_rem;
    logic [RemW-1:0]                  sq_root;
    logic [Lanes-1:0][DivRemW-1:0]    dv_rem;
    logic [Lanes-1:0][QuoW-1:0]       quo;
    logic [Lanes-1:0]                 ovf;
  } work_t;

endpackage

/* sv/r2q_prep.sv */
// front stage: trace test, lead selection, root argument and numerators
// depends on r2q_pkg
module r2q_prep (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  r2q_pkg::req_t     req_i,
  output logic              valid_o,
  output r2q_pkg::work_t    data_o
);

  localparam int unsigned TrW = r2q_pkg::DataW + 2;
  localparam int unsigned SW  = r2q_pkg::DataW + 3;

  r2q_pkg::work_t data_d, data_q;
  logic           valid_q;

  // pick path and form the exact integer terms
  always_comb begin
    logic signed [TrW-1:0] tr;
    logic signed [SW-1:0]  s;
    logic signed [TrW-1:0] a, b, c, one_ext;
    logic [1:0]            idx;
    data_d  = '0;
    one_ext = TrW'(r2q_pkg::One);
    a       = TrW'(req_i.m00);
    b       = TrW'(req_i.m11);
    c       = TrW'(req_i.m22);
    tr      = a + b + c;
    idx     = 2'd0;
    s       = '0;
    if (tr > 0) begin
      data_d.lead    = r2q_pkg::LEAD_W;
      s              = SW'(tr) + SW'(one_ext);
      data_d.diff[0] = r2q_pkg::DiffW'(req_i.m21) - r2q_pkg::DiffW'(req_i.m12);
      data_d.diff[1] = r2q_pkg::DiffW'(req_i.m02) - r2q_pkg::DiffW'(req_i.m20);
      data_d.diff[2] = r2q_pkg::DiffW'(req_i.m10) - r2q_pkg::DiffW'(req_i.m01);
    end else begin
      // ties keep the lower index
      if (req_i.m11 > req_i.m00) idx = 2'd1;
      if ((idx == 2'd1) ? (req_i.m22 > req_i.m11) : (req_i.m22 > req_i.m00)) idx = 2'd2;
      unique case (idx)
        2'd1: begin
          data_d.lead    = r2q_pkg::LEAD_Y;
          s              = SW'(b) - SW'(c) - SW'(a) + SW'(one_ext);
          data_d.diff[0] = r2q_pkg::DiffW'(req_i.m02) - r2q_pkg::DiffW'(req_i.m20);
          data_d.diff[1] = r2q_pkg::DiffW'(req_i.m01) + r2q_pkg::DiffW'(req_i.m10);
          data_d.diff[2] = r2q_pkg::DiffW'(req_i.m21) + r2q_pkg::DiffW'(req_i.m12);
        end
        2'd2: begin
          data_d.lead    = r2q_pkg::LEAD_Z;
          s              = SW'(c) - SW'(a) - SW'(b) + SW'(one_ext);
          data_d.diff[0] = r2q_pkg::DiffW'(req_i.m10) - r2q_pkg::DiffW'(req_i.m01);
          data_d.diff[1] = r2q_pkg::DiffW'(req_i.m02) + r2q_pkg::DiffW'(req_i.m20);
          data_d.diff[2] = r2q_pkg::DiffW'(req_i.m12) + r2q_pkg::DiffW'(req_i.m21);
        end
        default: begin
          data_d.lead    = r2q_pkg::LEAD_X;
          s              = SW'(a) - SW'(b) - SW'(c) + SW'(one_ext);
          data_d.diff[0] = r2q_pkg::DiffW'(req_i.m21) - r2q_pkg::DiffW'(req_i.m12);
          data_d.diff[1] = r2q_pkg::DiffW'(req_i.m10) + r2q_pkg::DiffW'(req_i.m01);
          data_d.diff[2] = r2q_pkg::DiffW'(req_i.m20) + r2q_pkg::DiffW'(req_i.m02);
        end
      endcase
    end
    data_d.deg     = (s <= 0);
    data_d.sq_rem  = data_d.deg ? '0
                   : (r2q_pkg::RemW'(unsigned'(s)) << r2q_pkg::FracBits);
    data_d.sq_root = '0;
  end

  // stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* sv/r2q_sqrt_stage.sv */
// one stage of the integer square root, a fixed group of digit steps
// depends on r2q_pkg
module r2q_sqrt_stage #(
  parameter int unsigned Index = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  r2q_pkg::work_t    data_i,
  output logic              valid_o,
  output r2q_pkg::work_t    data_o
);

  localparam int unsigned TopBit = 2 * (r2q_pkg::SqrtIters - 1);

  r2q_pkg::work_t data_d, data_q;
  logic           valid_q;

  // restoring root digits, bit walks down by two each step
  always_comb begin
    logic [r2q_pkg::RemW-1:0] trial;
    logic [r2q_pkg::RemW-1:0] bitv;
    data_d = data_i;
    for (int s = 0; s < r2q_pkg::StepsPerStage; s++) begin
      bitv  = r2q_pkg::RemW'(1) << (TopBit - 2 * (Index * r2q_pkg::StepsPerStage + s));
      trial = data_d.sq_root + bitv;
      if (data_d.sq_rem >= trial) begin
        data_d.sq_rem  = data_d.sq_rem - trial;
        data_d.sq_root = (data_d.sq_root >> 1) + bitv;
      end else begin
        data_d.sq_root = data_d.sq_root >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* sv/r2q_div_stage.sv */
// one stage of the three-lane rounded divide by twice the root
// depends on r2q_pkg
module r2q_div_stage #(
  parameter int unsigned Index = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  r2q_pkg::work_t    data_i,
  output logic              valid_o,
  output r2q_pkg::work_t    data_o
);

  localparam int unsigned DenW = r2q_pkg::DiffW + 1;

  r2q_pkg::work_t data_d, data_q;
  logic           valid_q;

  // first step loads the rounded numerator and checks for overflow,
  // later steps give one quotient bit each
  always_comb begin
    logic [r2q_pkg::DivRemW-1:0] den;
    logic [r2q_pkg::DivRemW-1:0] shifted;
    logic [r2q_pkg::DiffW-1:0]   mag;
    int                          t;
    data_d = data_i;
    den    = r2q_pkg::DivRemW'({data_i.sq_root[DenW-2:0], 1'b0});
    for (int s = 0; s < r2q_pkg::StepsPerStage; s++) begin
      t = Index * r2q_pkg::StepsPerStage + s;
      for (int l = 0; l < r2q_pkg::Lanes; l++) begin
        if (t == 0) begin
          mag = data_i.diff[l][r2q_pkg::DiffW-1] ? (~data_i.diff[l] + 1'b1) : data_i.diff[l];
          data_d.dv_rem[l] = (r2q_pkg::DivRemW'(mag) << r2q_pkg::FracBits)
                           + r2q_pkg::DivRemW'(data_i.sq_root[DenW-2:0]);
          data_d.ovf[l]    = data_d.dv_rem[l] >= (den << r2q_pkg::QuoW);
          data_d.quo[l]    = '0;
        end else begin
          shifted = den << (r2q_pkg::QuoW - t);
          if (data_d.dv_rem[l] >= shifted) begin
            data_d.dv_rem[l] = data_d.dv_rem[l] - shifted;
            data_d.quo[l][r2q_pkg::QuoW - t] = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* sv/r2q_out.sv */
// output stage: lead rounding, saturation, signs and lane placement
// depends on r2q_pkg
module r2q_out (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  r2q_pkg::work_t    data_i,
  output logic              valid_o,
  output r2q_pkg::rsp_t     rsp_o
);

  localparam int unsigned W = r2q_pkg::DataW;

  r2q_pkg::rsp_t rsp_d, rsp_q;
  logic          valid_q;

  always_comb begin
    logic [W:0]                          lead_v;
    logic [W-1:0]                        lead_s;
    logic [r2q_pkg::Lanes-1:0][W-1:0]    lane_v;
    logic [3:0][W-1:0]                   comp;
    logic [W-1:0]                        mag;
    int                                  li;
    // lead component rounds half up
    lead_v = (data_i.sq_root[W:0] + 1'b1) >> 1;
    lead_s = (lead_v > (W+1)'(r2q_pkg::One)) ? r2q_pkg::One : lead_v[W-1:0];
    // clamp and sign each lane
    for (int l = 0; l < r2q_pkg::Lanes; l++) begin
      mag = (data_i.ovf[l] || (W'(data_i.quo[l]) > r2q_pkg::One))
          ? r2q_pkg::One : W'(data_i.quo[l]);
      lane_v[l] = data_i.diff[l][r2q_pkg::DiffW-1] ? (~mag + 1'b1) : mag;
    end
    // place lanes around the lead component
    for (int c = 0; c < 4; c++) begin
      li = (c > int'(data_i.lead)) ? c - 1 : c;
      if (c == int'(data_i.lead)) begin
        comp[c] = lead_s;
      end else begin
        comp[c] = lane_v[li[1:0]];
      end
    end
    if (data_i.deg) begin
      comp = '0;
    end
    rsp_d.qw         = comp[0];
    rsp_d.qx         = comp[1];
    rsp_d.qy         = comp[2];
    rsp_d.qz         = comp[3];
    rsp_d.degenerate = data_i.deg;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rsp_q <= rsp_d;
    end
  end

  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

endmodule

/* sv/rotation_matrix_to_quaternion_core.sv */
// top level: rotation matrix to unit quaternion, ten-stage pipeline
// depends on r2q_pkg, r2q_prep, r2q_sqrt_stage, r2q_div_stage, r2q_out
//
//   channel  direction  handshake                 payload
//   in       to block   in_valid_i / in_stall_o   in_req_i  (r2q_pkg::req_t)
//   out      from block out_valid_o / out_stall_i out_rsp_o (r2q_pkg::rsp_t)
//
// one request per cycle while the output is not stalled; the stages are the front stage, four root
// stages of four digits, four divide stages of four steps and the output stage
// each stage holds while the one after it is full and held, so bubbles close
// up and the input stalls only when every stage is occupied
// reset clears only the stage valid bits
module rotation_matrix_to_quaternion_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  r2q_pkg::req_t   in_req_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output r2q_pkg::rsp_t   out_rsp_o
);

  localparam int unsigned N = r2q_pkg::NumStages;

  logic [N-1:0]          valid;
  logic [N-1:0]          en;
  r2q_pkg::work_t        work [N-1];

  // a stage loads when empty or when its contents move on
  always_comb begin
    en[N-1] = !valid[N-1] || !out_stall_i;
    for (int k = N - 2; k >= 0; k--) begin
      en[k] = !valid[k] || en[k+1];
    end
  end

  assign in_stall_o = !en[0];

  r2q_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en[0]),
    .valid_i (in_valid_i),
    .req_i   (in_req_i),
    .valid_o (valid[0]),
    .data_o  (work[0])
  );

  for (genvar g = 0; g < r2q_pkg::SqrtStages; g++) begin : g_sqrt
    r2q_sqrt_stage #(.Index(g)) u_sqrt (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en[1+g]),
      .valid_i (valid[g]),
      .data_i  (work[g]),
      .valid_o (valid[1+g]),
      .data_o  (work[1+g])
    );
  end

  for (genvar g = 0; g < r2q_pkg::DivStages; g++) begin : g_div
    r2q_div_stage #(.Index(g)) u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en[1+r2q_pkg::SqrtStages+g]),
      .valid_i (valid[r2q_pkg::SqrtStages+g]),
      .data_i  (work[r2q_pkg::SqrtStages+g]),
      .valid_o (valid[1+r2q_pkg::SqrtStages+g]),
      .data_o  (work[1+r2q_pkg::SqrtStages+g])
    );
  end

  r2q_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en[N-1]),
    .valid_i (valid[N-2]),
    .data_i  (work[N-2]),
    .valid_o (valid[N-1]),
    .rsp_o   (out_rsp_o)
  );

  assign out_valid_o = valid[N-1];

  // degenerate results carry zero components
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.degenerate |->
      out_rsp_o.qw == 0 && out_rsp_o.qx == 0 && out_rsp_o.qy == 0 && out_rsp_o.qz == 0)
    else $error("degenerate result with nonzero component");

  // an empty output stage never stalls the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output stage");

  // qw and qx stay inside plus or minus one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      $signed(out_rsp_o.qw) <= $signed({1'b0, r2q_pkg::One}) &&
      $signed(out_rsp_o.qw) >= -$signed({1'b0, r2q_pkg::One}) &&
      $signed(out_rsp_o.qx) <= $signed({1'b0, r2q_pkg::One}) &&
      $signed(out_rsp_o.qx) >= -$signed({1'b0, r2q_pkg::One}))
    else $error("component outside saturation range");

endmodule
